// ===== rtl/wfd_pkg.sv =====
// Shared constants and types for the wheel feedback frame decoder.
`timescale 1ns / 1ps

package wfd_pkg;

  localparam logic [7:0] CHAR_OPEN  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_CLOSE = 8'h42;  // 'B'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

  localparam int unsigned FIELD_COUNT = 4;
  localparam int unsigned FIELD_LEN   = 6;    // direction char + five digits
  localparam int unsigned FIELD_W     = $clog2(FIELD_COUNT + 1);
  localparam int unsigned FIELD_IDX_W = $clog2(FIELD_COUNT);
  localparam int unsigned CHAR_W      = $clog2(FIELD_LEN);

  localparam int unsigned MAG_W   = 17;       // holds 99999
  localparam int unsigned SPEED_W = 20;
  localparam int unsigned QUOT_W  = SPEED_W - 1;

  // floor(m * 256 / 70) == floor(m * 128 / 35) == (m * RECIP) >> RECIP_SHIFT,
  // exact for m below 2^17 (reciprocal error 6 * 2^24 stays under 2^30).
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP = 25'd30678338;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_CLEAR,
    REQ_WRITE,
    REQ_CLOSE
  } req_kind_e;

  // Request from the parser to the scaler / field store.
  typedef struct packed {
    req_kind_e              kind;
    logic [FIELD_IDX_W-1:0] field;
    logic [MAG_W-1:0]       mag;
    logic                   neg;
    logic                   complete;
  } parse_req_t;

  typedef logic signed [SPEED_W-1:0] speed_t;

endpackage : wfd_pkg

// ===== rtl/wfd_parser.sv =====
// Byte parser: frame state, field/char position, direction and magnitude.
`timescale 1ns / 1ps

module wfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  output wfd_pkg::parse_req_t req_o
);
  import wfd_pkg::*;

  logic                   in_frame_q, in_frame_d;
  logic [FIELD_W-1:0]     field_q, field_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   neg_q, neg_d;
  logic                   ended_q, ended_d;
  logic [MAG_W-1:0]       mag_q, mag_d;
  parse_req_t             req_q, req_d;
  logic                   payload_done;
  logic                   is_digit;
  logic [MAG_W-1:0]       digit_val;

  assign payload_done = (field_q == FIELD_W'(FIELD_COUNT));
  assign is_digit     = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit_val    = MAG_W'(byte_i - CHAR_ZERO);

  always_comb begin
    in_frame_d = in_frame_q;
    field_d    = field_q;
    char_d     = char_q;
    neg_d      = neg_q;
    ended_d    = ended_q;
    mag_d      = mag_q;
    req_d      = '0;
    req_d.kind = REQ_NONE;

    if (byte_valid_i) begin
      if (byte_i == CHAR_OPEN) begin
        in_frame_d = 1'b1;
        field_d    = '0;
        char_d     = '0;
        neg_d      = 1'b0;
        ended_d    = 1'b0;
        mag_d      = '0;
        req_d.kind = REQ_CLEAR;
      end else if (in_frame_q && (byte_i == CHAR_CLOSE)) begin
        in_frame_d     = 1'b0;
        req_d.kind     = REQ_CLOSE;
        req_d.complete = payload_done;
      end else if (in_frame_q && !payload_done) begin
        if (char_q == '0) begin
          if (byte_i == CHAR_ZERO) begin
            neg_d = 1'b1;
          end else if (byte_i == CHAR_ONE) begin
            neg_d = 1'b0;
          end
          ended_d = 1'b0;
          mag_d   = '0;
        end else if (!ended_q && is_digit) begin
          mag_d = (mag_q << 3) + (mag_q << 1) + digit_val;
        end else begin
          ended_d = 1'b1;
        end
        if (char_q == CHAR_W'(FIELD_LEN - 1)) begin
          char_d  = '0;
          field_d = field_q + 1'b1;
        end else begin
          char_d = char_q + 1'b1;
        end
        req_d.kind  = REQ_WRITE;
        req_d.field = field_q[FIELD_IDX_W-1:0];
        req_d.mag   = mag_d;
        req_d.neg   = neg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      field_q    <= '0;
      char_q     <= '0;
      neg_q      <= 1'b0;
      ended_q    <= 1'b0;
      mag_q      <= '0;
      req_q      <= '0;
    end else if (advance_i) begin
      in_frame_q <= in_frame_d;
      field_q    <= field_d;
      char_q     <= char_d;
      neg_q      <= neg_d;
      ended_q    <= ended_d;
      mag_q      <= mag_d;
      req_q      <= req_d;
    end
  end

  assign req_o = req_q;

endmodule : wfd_parser

// ===== rtl/wfd_scaler.sv =====
// Magnitude to Q8 speed scaling and the per-field speed store.
`timescale 1ns / 1ps

module wfd_scaler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  wfd_pkg::parse_req_t req_i,
  output logic                res_valid_o,
  output wfd_pkg::speed_t     speed_o [wfd_pkg::FIELD_COUNT],
  output logic                complete_o
);
  import wfd_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  speed_t            speed_new;
  speed_t            speed_q [FIELD_COUNT];

  // Reciprocal multiply replaces the divide by 70.
  assign prod      = PROD_W'(req_i.mag) * PROD_W'(RECIP);
  assign quot      = prod[RECIP_SHIFT +: QUOT_W];
  assign speed_new = req_i.neg ? -speed_t'({1'b0, quot}) : speed_t'({1'b0, quot});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        speed_q[i] <= '0;
      end
    end else if (advance_i) begin
      unique case (req_i.kind)
        REQ_CLEAR: begin
          for (int i = 0; i < FIELD_COUNT; i++) begin
            speed_q[i] <= '0;
          end
        end
        REQ_WRITE: speed_q[req_i.field] <= speed_new;
        REQ_NONE,
        REQ_CLOSE: ;
        default: ;
      endcase
    end
  end

  assign res_valid_o = advance_i && (req_i.kind == REQ_CLOSE);
  assign speed_o     = speed_q;
  assign complete_o  = req_i.complete;

endmodule : wfd_scaler

// ===== rtl/wheel_feedback_frame_decoder.sv =====
// Wheel feedback frame decoder top level: input register, parser, scaler, result register.
`timescale 1ns / 1ps
// A closing 'B' request passes the input, parser and result registers to the master side.
// One byte per cycle is taken; the only stall is a closing request that meets a full
//   result register whose request is not yet taken (the input register then fills).
// Reset (rst_ni low, asynchronous): no frame open, field speeds zero, all stages empty.

module wheel_feedback_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [19:0] speed_front_left, [39:20] speed_back_left,
                                      // [59:40] speed_back_right, [79:60] speed_front_right
  output logic [0:0]  m_axis_tuser    // [0] frame_complete
);
  import wfd_pkg::*;

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // Pipeline control
  logic       advance;
  parse_req_t req;

  // Scaler outputs
  logic       res_valid;
  speed_t     speed [FIELD_COUNT];
  logic       complete;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [79:0] out_data_q;
  logic        out_user_q;

  // Everything moves unless a close request is waiting on a held result.
  assign advance = !((req.kind == REQ_CLOSE) && out_valid_q && !m_axis_tready);

  // Input register takes a new byte whenever its current one moves on (or it is empty).
  assign s_axis_tready = advance || !in_valid_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .byte_valid_i (in_valid_q),
    .byte_i       (in_byte_q),
    .req_o        (req)
  );

  wfd_scaler u_scaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .req_i       (req),
    .res_valid_o (res_valid),
    .speed_o     (speed),
    .complete_o  (complete)
  );

  // Result register: loads a frame result, clears once the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= {speed[3], speed[2], speed[1], speed[0]};
      out_user_q <= complete;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule : wheel_feedback_frame_decoder
